FILE: hw/rtl/pp_pkg.sv
// Shared types and constants for the polygon perimeter block.
package pp_pkg;

   // Width of the perimeter accumulator and its saturation value.
   localparam int SUM_W = 40;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // Depth of the edge queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SQX,
      BK_SQY,
      BK_START,
      BK_ROOT,
      BK_EMIT
   } pp_back_state_type;

endpackage

FILE: hw/rtl/pp_front.sv
// Front end: accepts vertices, tracks the first and previous vertex, and queues edge jobs.
module pp_front #(
   parameter int COORD_BITS = 16,
   localparam int JOB_W = 2 * COORD_BITS + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic signed [COORD_BITS-1:0] req_x,
   input  logic signed [COORD_BITS-1:0] req_y,
   input  logic                         req_last,
   output logic                         job_valid,
   input  logic                         job_ready,
   output logic [JOB_W-1:0]             job_data   // {final, |dy|, |dx|}
);

   logic signed [COORD_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [COORD_BITS-1:0] close_x, close_y;
   logic                         have_vertex_ff, have_vertex_in;
   logic                         hold_valid_ff, hold_valid_in;
   logic [JOB_W-1:0]             hold_job_ff, hold_job_in;
   logic [JOB_W-1:0]             prev_job, close_job;
   logic                         accept;

   // Magnitude of the difference of two signed coordinates; it always fits in COORD_BITS.
   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] d;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      if (d[COORD_BITS]) begin
         d = -d;
      end
      return d[COORD_BITS-1:0];
   endfunction

   // A new vertex is taken only when no closing edge is waiting and the queue has room.
   assign req_tready = !hold_valid_ff && job_ready;
   assign accept     = req_tvalid && req_tready;

   // The closing edge of a single-vertex polygon runs from the vertex to itself.
   assign close_x   = have_vertex_ff ? first_x_ff : req_x;
   assign close_y   = have_vertex_ff ? first_y_ff : req_y;
   assign prev_job  = {1'b0, abs_diff(req_y, prev_y_ff), abs_diff(req_x, prev_x_ff)};
   assign close_job = {1'b1, abs_diff(req_y, close_y), abs_diff(req_x, close_x)};

   // Per vertex: the edge from the previous vertex, if any, plus the closing edge if last.
   always_comb begin
      job_valid      = 1'b0;
      job_data       = prev_job;
      hold_valid_in  = hold_valid_ff;
      hold_job_in    = hold_job_ff;
      have_vertex_in = have_vertex_ff;
      first_x_in     = first_x_ff;
      first_y_in     = first_y_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      if (hold_valid_ff) begin
         job_valid = 1'b1;
         job_data  = hold_job_ff;
         if (job_ready) begin
            hold_valid_in = 1'b0;
         end
      end else if (accept) begin
         prev_x_in = req_x;
         prev_y_in = req_y;
         if (have_vertex_ff) begin
            job_valid = 1'b1;
            if (req_last) begin
               hold_valid_in  = 1'b1;
               hold_job_in    = close_job;
               have_vertex_in = 1'b0;
            end
         end else begin
            first_x_in = req_x;
            first_y_in = req_y;
            if (req_last) begin
               job_valid = 1'b1;
               job_data  = close_job;
            end else begin
               have_vertex_in = 1'b1;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         have_vertex_ff <= 1'b0;
         hold_valid_ff  <= 1'b0;
      end else begin
         have_vertex_ff <= have_vertex_in;
         hold_valid_ff  <= hold_valid_in;
      end
   end

   // Vertex and pending job storage.
   always_ff @(posedge clock) begin
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      hold_job_ff <= hold_job_in;
   end

endmodule

FILE: hw/rtl/pp_queue.sv
// Short FIFO that carries edge jobs from the front end to the back end.
module pp_queue import pp_pkg::*; #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/pp_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module pp_sqrt #(
   parameter int ROOT_W = 25,
   localparam int RAD_W = 2 * ROOT_W,
   localparam int CNT_W = $clog2(ROOT_W + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              busy,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+2:0] shifted, trial, diff;
   logic              take;

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

   // One restoring step: bring down two radicand bits and try the next root bit.
   assign shifted = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign diff    = shifted - trial;
   assign take    = (shifted >= trial);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(ROOT_W);
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         count_in = count_ff - 1'b1;
         rad_in   = rad_ff << 2;
         rem_in   = take ? diff[ROOT_W:0] : shifted[ROOT_W:0];
         root_in  = {root_ff[ROOT_W-2:0], take};
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

FILE: hw/rtl/pp_back.sv
// Back end: squares each edge, runs the root, accumulates and emits the perimeter.
module pp_back import pp_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS = 8,
   localparam int JOB_W = 2 * COORD_BITS + 1,
   localparam int ROOT_W = COORD_BITS + 1 + FRAC_BITS,
   localparam int RAD_W = 2 * ROOT_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  logic [JOB_W-1:0]  job_data,
   output logic              sq_start,
   output logic [RAD_W-1:0]  sq_radicand,
   input  logic              sq_done,
   input  logic [ROOT_W-1:0] sq_root,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [SUM_W-1:0]  rsp_perimeter,
   output logic              rsp_saturated
);

   localparam int SQ_W = 2 * COORD_BITS;
   localparam int ADD_W = ((ROOT_W > SUM_W) ? ROOT_W : SUM_W) + 1;

   pp_back_state_type state_ff, state_in;

   logic [COORD_BITS-1:0] ux_ff, uy_ff, mul_op;
   logic                  final_ff;
   logic [SQ_W-1:0]       prod_ff, sqx_ff;
   logic [SQ_W:0]         sq_sum;
   logic [ADD_W-1:0]      add_sum;
   logic [SUM_W-1:0]      sum_ff, sum_in, out_perim_ff;
   logic                  sat_ff, sat_in, out_sat_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  load_job, acc_en, emit_en;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (job_valid) begin
            state_in = BK_SQX;
         end
         BK_SQX:   state_in = BK_SQY;
         BK_SQY:   state_in = BK_START;
         BK_START: state_in = BK_ROOT;
         BK_ROOT:  if (sq_done) begin
            state_in = final_ff ? BK_EMIT : BK_IDLE;
         end
         BK_EMIT:  if (!out_valid_ff || rsp_tready) begin
            state_in = BK_IDLE;
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   // State-decoded controls.
   always_comb begin
      job_ready = 1'b0;
      sq_start  = 1'b0;
      acc_en    = 1'b0;
      emit_en   = 1'b0;
      mul_op    = uy_ff;
      unique case (state_ff)
         BK_IDLE:  job_ready = 1'b1;
         BK_SQX:   mul_op = ux_ff;
         BK_SQY:   mul_op = uy_ff;
         BK_START: sq_start = 1'b1;
         BK_ROOT:  acc_en = sq_done;
         BK_EMIT:  emit_en = !out_valid_ff || rsp_tready;
         default:  job_ready = 1'b0;
      endcase
   end

   assign load_job = job_valid && job_ready;

   // Squared length scaled by the fraction bits forms the radicand.
   assign sq_sum      = {1'b0, sqx_ff} + {1'b0, prod_ff};
   assign sq_radicand = RAD_W'(sq_sum) << (2 * FRAC_BITS);

   // Saturating accumulation of edge lengths; emission clears the polygon sum.
   assign add_sum = ADD_W'(sum_ff) + ADD_W'(sq_root);

   always_comb begin
      sum_in       = sum_ff;
      sat_in       = sat_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (acc_en) begin
         if (add_sum[ADD_W-1:SUM_W] != '0) begin
            sum_in = SUM_MAX;
            sat_in = 1'b1;
         end else begin
            sum_in = add_sum[SUM_W-1:0];
         end
      end else if (emit_en) begin
         sum_in       = '0;
         sat_in       = 1'b0;
         out_valid_in = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Job capture, shared squarer and result register.
   always_ff @(posedge clock) begin
      if (load_job) begin
         ux_ff    <= job_data[COORD_BITS-1:0];
         uy_ff    <= job_data[2*COORD_BITS-1:COORD_BITS];
         final_ff <= job_data[JOB_W-1];
      end
      prod_ff <= SQ_W'(mul_op) * SQ_W'(mul_op);
      if (state_ff == BK_SQY) begin
         sqx_ff <= prod_ff;
      end
      if (emit_en) begin
         out_perim_ff <= sum_ff;
         out_sat_ff   <= sat_ff;
      end
   end

   assign rsp_tvalid    = out_valid_ff;
   assign rsp_perimeter = out_perim_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

FILE: hw/rtl/polygon_perimeter_top.sv
// Polygon perimeter top level: front end, edge queue, square-root unit and back end.
//
// Vertices stream in one request at a time; every vertex after the first of a polygon
// yields one edge, and the vertex marked last also yields the closing edge back to the
// first vertex, after which the perimeter (unsigned, FRAC_BITS fraction bits, saturating
// at 2^40 - 1) and a saturation flag are sent. A single vertex gives zero. Each edge
// passes through the back end as a queue pop, two passes through the shared squarer,
// the root start, the bit-serial square-root unit, which sets the throughput, and the
// capture of the root. A last vertex adds the closing edge and a result-register load.
// The front end keeps accepting vertices until the four-entry queue fills, and it
// pauses after the last vertex of a longer polygon until its closing edge is queued.
module polygon_perimeter_top import pp_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]      req_tdata,  // x_coord, y_coord
   input  logic                                   req_tlast,  // is_last
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [SUM_W-1:0]                       rsp_tdata,  // perimeter
   output logic [0:0]                             rsp_tuser   // saturated
);

   localparam int JOB_W = 2 * COORD_BITS + 1;
   localparam int ROOT_W = COORD_BITS + 1 + FRAC_BITS;
   localparam int RAD_W = 2 * ROOT_W;

   logic                         fr_valid, fr_ready, bk_valid, bk_ready;
   logic [JOB_W-1:0]             fr_data, bk_data;
   logic                         sq_start, sq_busy, sq_done;
   logic [RAD_W-1:0]             sq_radicand;
   logic [ROOT_W-1:0]            sq_root;
   logic                         rsp_sat;

   // Vertex intake.
   pp_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_x      (req_tdata[COORD_BITS-1:0]),
      .req_y      (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .req_last   (req_tlast),
      .job_valid  (fr_valid),
      .job_ready  (fr_ready),
      .job_data   (fr_data)
   );

   // Edge queue.
   pp_queue #(
      .WIDTH(JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_data),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_data   (bk_data)
   );

   // Square-root unit.
   pp_sqrt #(
      .ROOT_W(ROOT_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_radicand),
      .busy     (sq_busy),
      .done     (sq_done),
      .root     (sq_root)
   );

   // Edge arithmetic and result.
   pp_back #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (bk_valid),
      .job_ready     (bk_ready),
      .job_data      (bk_data),
      .sq_start      (sq_start),
      .sq_radicand   (sq_radicand),
      .sq_done       (sq_done),
      .sq_root       (sq_root),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_perimeter (rsp_tdata),
      .rsp_saturated (rsp_sat)
   );

   assign rsp_tuser = rsp_sat;

`ifndef ASSERT_OFF
   // The root unit is never restarted while it is still working.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      sq_start |-> !sq_busy)
      else $error("square root started while busy");

   // A root completes only at the end of a busy run.
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> $past(sq_busy) && !sq_busy)
      else $error("square root done without a preceding busy run");

   // A saturated result always carries the full-scale perimeter.
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == SUM_MAX)
      else $error("saturated result without full-scale perimeter");
`endif

endmodule

FILE: test/polygon_perimeter_top_tb.sv
// Self-checking testbench for the polygon perimeter block.
`timescale 1ns / 100ps

module polygon_perimeter_top_tb;
   import pp_pkg::*;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS = 8;
   localparam int REQ_W = ((2*COORD_BITS+7)/8)*8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_VERTICES = 930;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      logic [SUM_W-1:0] perimeter;
      logic             saturated;
   } perimeter_result_type;

   // Tracks the polygon under construction and the perimeters still owed by the block.
   class perimeter_tracker;
      coord_type            first_x, first_y, prev_x, prev_y;
      bit                   have_vertex;
      logic [SUM_W-1:0]     running_sum;
      bit                   sum_saturated;
      perimeter_result_type pending_perimeters[$];
      int                   error_count;

      function new();
         error_count = 0;
         clear_polygon();
      endfunction

      function void clear_polygon();
         first_x = '0;
         first_y = '0;
         prev_x = '0;
         prev_y = '0;
         have_vertex = 0;
         running_sum = '0;
         sum_saturated = 0;
      endfunction

      // Floor of the edge length scaled by 2^FRAC_BITS, found bit by bit.
      function logic [31:0] edge_length(coord_type ax, coord_type ay,
                                        coord_type bx, coord_type by);
         logic signed [COORD_BITS+1:0] dx, dy;
         logic [COORD_BITS+1:0]        ux, uy;
         logic [63:0]                  radicand;
         logic [31:0]                  root, trial;
         dx = (COORD_BITS+2)'(ax) - (COORD_BITS+2)'(bx);
         dy = (COORD_BITS+2)'(ay) - (COORD_BITS+2)'(by);
         ux = (dx < 0) ? -dx : dx;
         uy = (dy < 0) ? -dy : dy;
         radicand = (64'(ux) * 64'(ux) + 64'(uy) * 64'(uy)) << (2*FRAC_BITS);
         root = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= radicand) begin
               root = trial;
            end
         end
         return root;
      endfunction

      function void add_edge(logic [31:0] len);
         logic [SUM_W:0] total;
         total = {1'b0, running_sum} + (SUM_W+1)'(len);
         if (total > (SUM_W+1)'(SUM_MAX)) begin
            running_sum = SUM_MAX;
            sum_saturated = 1;
         end else begin
            running_sum = total[SUM_W-1:0];
         end
      endfunction

      // Called for every accepted vertex request.
      function void accept_vertex(coord_type x, coord_type y, bit last);
         perimeter_result_type res;
         if (!have_vertex) begin
            first_x = x;
            first_y = y;
            have_vertex = 1;
         end else begin
            add_edge(edge_length(x, y, prev_x, prev_y));
         end
         prev_x = x;
         prev_y = y;
         if (last) begin
            add_edge(edge_length(x, y, first_x, first_y));
            res.perimeter = running_sum;
            res.saturated = sum_saturated;
            pending_perimeters.push_back(res);
            clear_polygon();
         end
      endfunction

      // Called for every accepted result; compares it with the oldest owed perimeter.
      function void check_perimeter(logic [SUM_W-1:0] perimeter, logic saturated);
         perimeter_result_type exp_res;
         if (pending_perimeters.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result perimeter=%0d saturated=%0d",
                     $time, perimeter, saturated);
            return;
         end
         exp_res = pending_perimeters.pop_front();
         if (perimeter !== exp_res.perimeter) begin
            error_count++;
            $display("%0t: perimeter mismatch, expected %0d, actual %0d",
                     $time, exp_res.perimeter, perimeter);
         end
         if (saturated !== exp_res.saturated) begin
            error_count++;
            $display("%0t: saturated mismatch, expected %0d, actual %0d",
                     $time, exp_res.saturated, saturated);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // x_coord, y_coord
   logic             req_tlast;   // is_last
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [SUM_W-1:0] rsp_tdata;   // perimeter
   logic [0:0]       rsp_tuser;   // saturated

   perimeter_tracker tracker = new();
   int               gap_max = 16;
   int               idle_cycles = 0;

   polygon_perimeter_top #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Free-running 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Check every accepted result against the oldest owed perimeter.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_perimeter(rsp_tdata, rsp_tuser[0]);
      end
   end

   // Stop the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: stall a random number of cycles before taking each result.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, gap_max);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Send one vertex request after a random gap and wait for it to be taken.
   task automatic send_vertex(coord_type x, coord_type y, bit last);
      int gap;
      gap = $urandom_range(0, gap_max);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({y, x});
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.accept_vertex(x, y, last);
   endtask

   function automatic coord_type random_coord(int mode);
      int offset;
      case (mode)
         0: return coord_type'($urandom);
         1: begin
            offset = $urandom_range(0, 64);
            return coord_type'(offset - 32);
         end
         default: begin
            case ($urandom_range(0, 4))
               0: return coord_type'(16'h8000);
               1: return coord_type'(16'h7fff);
               2: return coord_type'(16'hffff);
               3: return coord_type'(16'h0000);
               default: return coord_type'($urandom);
            endcase
         end
      endcase
   endfunction

   // Main stimulus: directed polygons, then random polygons.
   initial begin
      int sent;
      int count;
      int mode;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single vertices close onto themselves and give zero.
      send_vertex(16'sd0, 16'sd0, 1);
      send_vertex(-16'sd32768, 16'sd32767, 1);
      // Edges of whole length out from the origin and back, where the root is exact.
      send_vertex(16'sd0, 16'sd0, 0);
      send_vertex(16'sd3, 16'sd4, 1);
      // Longest possible edge, corner to corner.
      send_vertex(-16'sd32768, -16'sd32768, 0);
      send_vertex(16'sd32767, 16'sd32767, 1);
      // Triangle over the opposite corners.
      send_vertex(16'sd32767, -16'sd32768, 0);
      send_vertex(-16'sd32768, 16'sd32767, 0);
      send_vertex(16'sd32767, 16'sd32767, 1);
      // Repeated vertex gives zero-length edges.
      send_vertex(16'sd100, -16'sd100, 0);
      send_vertex(16'sd100, -16'sd100, 0);
      send_vertex(16'sd100, -16'sd100, 1);
      // Small square around the origin.
      send_vertex(-16'sd1, -16'sd1, 0);
      send_vertex(16'sd1, -16'sd1, 0);
      send_vertex(16'sd1, 16'sd1, 0);
      send_vertex(-16'sd1, 16'sd1, 1);
      // Axis-aligned full-span edge, then a near-horizontal full-span edge.
      send_vertex(16'sd0, -16'sd32768, 0);
      send_vertex(16'sd0, 16'sd32767, 1);
      send_vertex(-16'sd1, 16'sd0, 0);
      send_vertex(-16'sd32768, 16'sd0, 0);
      send_vertex(16'sd32767, -16'sd1, 1);

      // Random polygons of mostly small vertex counts, with idling that changes over time.
      gap_max = 16;
      sent = 0;
      while (sent < RANDOM_VERTICES) begin
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0: gap_max = 0;
               1: gap_max = 2;
               default: gap_max = 16;
            endcase
         end
         case ($urandom_range(0, 9))
            0: count = 1;
            1: count = $urandom_range(9, 20);
            default: count = $urandom_range(2, 8);
         endcase
         mode = $urandom_range(0, 3);
         for (int v = 0; v < count; v++) begin
            send_vertex(random_coord(mode == 3 ? $urandom_range(0, 2) : mode),
                        random_coord(mode == 3 ? $urandom_range(0, 2) : mode),
                        v == count - 1);
         end
         sent += count;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;

      // Drain owed perimeters, then give the block time to show any stray result.
      while (tracker.pending_perimeters.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (tracker.error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
